/* rtl/assert_macros.svh */
// assertion helpers, included by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define GCRT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define GCRT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/gcrt_pkg.sv */
// ----------------------------------------------------------------------------
// gcrt_pkg
// Shared constants, codes and types of the grid cell residency tracker.
// ----------------------------------------------------------------------------
package gcrt_pkg;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;
   localparam int CELLS     = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int GRID_MAX  = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
   localparam int COORD_W   = $clog2(GRID_MAX + 1);
   localparam int CNT_W     = 13;
   localparam int CFG_W     = 16;
   localparam int CFG_IDX_W = 3;
   localparam int CFG_NUM   = 8;
   localparam int POS_W     = 32;
   localparam int LOC_W     = 6;
   localparam int EDGE_W    = 36;
   localparam int EDGE_NUM  = 12;
   localparam int EDGE_IDX_W = $clog2(EDGE_NUM);
   localparam int DIV_NUM_W  = EDGE_W - 1;
   localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);

   typedef enum logic [1:0] {
      ST_UNLOADED = 2'd0,
      ST_LOADED   = 2'd1,
      ST_SHOWN    = 2'd2,
      ST_HIDDEN   = 2'd3
   } status_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_CELL_WIDTH  = 3'd0,
      REG_CELL_HEIGHT = 3'd1,
      REG_VIEW_UP     = 3'd2,
      REG_VIEW_DOWN   = 3'd3,
      REG_VIEW_LEFT   = 3'd4,
      REG_VIEW_RIGHT  = 3'd5,
      REG_BORDER_X    = 3'd6,
      REG_BORDER_Y    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
   } rect_type;

   typedef struct packed {
      logic                start;
      logic                ceil_mode;
      logic [EDGE_W-1:0]   dividend;
      logic [CFG_W-1:0]    divisor;
      logic [COORD_W-1:0]  limit;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] row,
                                                   logic [COORD_W-1:0] col);
      return ADDR_W'(int'(row) * GRID_COLS + int'(col));
   endfunction

endpackage

/* rtl/gcrt_if.sv */
// ----------------------------------------------------------------------------
// gcrt_if
// Request and response channels of the grid cell residency tracker.
// ----------------------------------------------------------------------------
interface gcrt_req_if;
   import gcrt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic signed [POS_W-1:0] view_x;
   logic signed [POS_W-1:0] view_y;
   logic [LOC_W-1:0]        cell_col;
   logic [LOC_W-1:0]        cell_row;

   modport source (output valid, kind, view_x, view_y, cell_col, cell_row, input ready);
   modport sink (input valid, kind, view_x, view_y, cell_col, cell_row, output ready);
endinterface

interface gcrt_rsp_if;
   import gcrt_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       cell_status;
   logic             region_changed;
   logic [CNT_W-1:0] unloaded_count;
   logic [CNT_W-1:0] loaded_count;
   logic [CNT_W-1:0] shown_count;
   logic [CNT_W-1:0] hidden_count;

   modport source (output valid, cell_status, region_changed, unloaded_count,
                   loaded_count, shown_count, hidden_count, input ready);
   modport sink (input valid, cell_status, region_changed, unloaded_count,
                 loaded_count, shown_count, hidden_count, output ready);
endinterface

/* rtl/gcrt_ram.sv */
// ----------------------------------------------------------------------------
// gcrt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gcrt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/gcrt_div.sv */
// ----------------------------------------------------------------------------
// gcrt_div
// Floor or ceiling division of a rectangle edge by the cell size, one
// quotient bit per cycle, result clamped to [0, limit].
// ----------------------------------------------------------------------------
module gcrt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gcrt_pkg::div_req_type req,
   output gcrt_pkg::div_rsp_type rsp
);
   import gcrt_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_type;

   dstate_type             state_ff, state_in;
   logic [DIV_NUM_W-1:0]   num_ff, num_in;
   logic [DIV_NUM_W-1:0]   quo_ff, quo_in;
   logic [CFG_W-1:0]       rem_ff, rem_in;
   logic [CFG_W-1:0]       den_ff, den_in;
   logic [DIV_STEP_W-1:0]  step_ff, step_in;
   logic                   ceil_ff, ceil_in;
   logic [COORD_W-1:0]     lim_ff, lim_in;
   logic [COORD_W-1:0]     res_ff, res_in;
   logic                   done_ff, done_in;
   logic [CFG_W:0]         trial;
   logic [CFG_W:0]         diff;
   logic [DIV_NUM_W:0]     qadj;
   logic [EDGE_W-1:0]      num_src;

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      step_in  = step_ff;
      ceil_in  = ceil_ff;
      lim_in   = lim_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff     = trial - {1'b0, den_ff};
      qadj     = {1'b0, quo_ff} + (DIV_NUM_W + 1)'(ceil_ff);
      // ceiling of a positive value is floor of (value - 1) plus one
      num_src  = req.dividend - EDGE_W'(req.ceil_mode);
      case (state_ff)
         D_IDLE: begin
            if (req.start) begin
               ceil_in = req.ceil_mode;
               lim_in  = req.limit;
               den_in  = (req.divisor == '0) ? CFG_W'(1) : req.divisor;
               rem_in  = '0;
               quo_in  = '0;
               step_in = '0;
               num_in  = num_src[DIV_NUM_W-1:0];
               // negative edges, and a zero upper edge, clamp to zero
               if (req.dividend[EDGE_W-1] || (req.ceil_mode && req.dividend == '0)) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            if (!diff[CFG_W]) begin
               rem_in = diff[CFG_W-1:0];
               quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CFG_W-1:0];
               quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
            end
            num_in  = {num_ff[DIV_NUM_W-2:0], 1'b0};
            step_in = step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(DIV_NUM_W - 1)) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (qadj > (DIV_NUM_W + 1)'(lim_ff)) begin
               res_in = lim_ff;
            end else begin
               res_in = qadj[COORD_W-1:0];
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
      ceil_ff <= ceil_in;
      lim_ff  <= lim_in;
      res_ff  <= res_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = res_ff;
endmodule

/* rtl/grid_cell_residency_tracker.sv */
// Read item: the status read is registered, then held in the result register.
// Update item: twelve rectangle edges through one shared bit-serial divider,
// then, if the aligned view changed, one cell per cycle of the old and of the
// new preload region through the status memory.
// One item at a time; a new request is taken while a result waits.
// After reset a clearing pass sets every cell unloaded.
// ----------------------------------------------------------------------------
// grid_cell_residency_tracker
// Keeps a residency status per grid cell in a status memory and walks the
// preload regions on each change of the aligned view.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_cell_residency_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [gcrt_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [gcrt_pkg::CFG_W-1:0]      csr_wdata,
   gcrt_req_if.sink                        req_chan,
   gcrt_rsp_if.source                      rsp_chan
);
   import gcrt_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_EDGE, S_EDGE_WAIT, S_CHECK,
      S_PASS, S_WALK, S_DRAIN, S_FINISH, S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        cfg_ff [CFG_NUM];
   logic [CFG_W-1:0]        cfg_in [CFG_NUM];
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic signed [POS_W-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [COORD_W-1:0]      edge_ff [EDGE_NUM];
   logic [COORD_W-1:0]      edge_in [EDGE_NUM];
   logic [EDGE_IDX_W-1:0]   e_ff, e_in;
   rect_type                prev_view_ff, prev_view_in, prev_pre_ff, prev_pre_in;
   logic                    pass_ff, pass_in;
   logic [COORD_W-1:0]      c_ff, c_in, r_ff, r_in;
   logic                    p_valid_ff, p_valid_in;
   logic [ADDR_W-1:0]       p_addr_ff, p_addr_in;
   status_type              p_status_ff, p_status_in;
   logic [CNT_W-1:0]        cnt_ff [4];
   logic [CNT_W-1:0]        cnt_in [4];
   logic                    rd_ok_ff, rd_ok_in;
   status_type              res_status_ff, res_status_in;
   logic                    res_changed_ff, res_changed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_changed_ff, rsp_changed_in;
   logic [CNT_W-1:0]        rsp_cnt_ff [4];
   logic [CNT_W-1:0]        rsp_cnt_in [4];

   rect_type                new_view, new_pre, new_keep, cur;
   logic [COORD_W-1:0]      cx0, cy0, cx1, cy1;
   logic                    in_common, in_view, in_keep, cur_empty;
   logic                    req_xfer;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [1:0]              ram_wdata, ram_rdata;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic [1:0]              e_side, e_group;
   logic [EDGE_W-1:0]       pos, ext_lo, ext_hi, margin;
   logic [CFG_W-1:0]        bord;
   logic [CFG_W+1:0]        bord3;

   assign new_view = '{x0: edge_ff[0], y0: edge_ff[1], x1: edge_ff[2], y1: edge_ff[3]};
   assign new_pre  = '{x0: edge_ff[4], y0: edge_ff[5], x1: edge_ff[6], y1: edge_ff[7]};
   assign new_keep = '{x0: edge_ff[8], y0: edge_ff[9], x1: edge_ff[10], y1: edge_ff[11]};
   assign cur      = pass_ff ? new_pre : prev_pre_ff;
   assign cur_empty = (cur.x0 >= cur.x1) || (cur.y0 >= cur.y1);

   // overlap of old and new view
   assign cx0 = (prev_view_ff.x0 > new_view.x0) ? prev_view_ff.x0 : new_view.x0;
   assign cy0 = (prev_view_ff.y0 > new_view.y0) ? prev_view_ff.y0 : new_view.y0;
   assign cx1 = (prev_view_ff.x1 < new_view.x1) ? prev_view_ff.x1 : new_view.x1;
   assign cy1 = (prev_view_ff.y1 < new_view.y1) ? prev_view_ff.y1 : new_view.y1;
   assign in_common = (c_ff >= cx0) && (c_ff < cx1) && (r_ff >= cy0) && (r_ff < cy1);
   assign in_view = (c_ff >= new_view.x0) && (c_ff < new_view.x1) &&
                    (r_ff >= new_view.y0) && (r_ff < new_view.y1);
   assign in_keep = (c_ff >= new_keep.x0) && (c_ff < new_keep.x1) &&
                    (r_ff >= new_keep.y0) && (r_ff < new_keep.y1);

   // edge operand: side 0 x0, 1 y0, 2 x1, 3 y1; group 0 view, 1 preload, 2 persist
   assign e_side  = e_ff[1:0];
   assign e_group = e_ff[3:2];

   always_comb begin
      pos    = e_side[0] ? {{(EDGE_W-POS_W){vy_ff[POS_W-1]}}, vy_ff}
                         : {{(EDGE_W-POS_W){vx_ff[POS_W-1]}}, vx_ff};
      ext_lo = EDGE_W'(e_side[0] ? cfg_ff[REG_VIEW_DOWN] : cfg_ff[REG_VIEW_LEFT]);
      ext_hi = EDGE_W'(e_side[0] ? cfg_ff[REG_VIEW_UP] : cfg_ff[REG_VIEW_RIGHT]);
      bord   = e_side[0] ? cfg_ff[REG_BORDER_Y] : cfg_ff[REG_BORDER_X];
      bord3  = {1'b0, bord, 1'b0} + (CFG_W + 2)'(bord);
      case (e_group)
         2'd0:    margin = '0;
         2'd1:    margin = EDGE_W'(bord);
         2'd2:    margin = EDGE_W'(bord3);
         default: margin = '0;
      endcase
      div_req.start     = (state_ff == S_EDGE);
      div_req.ceil_mode = e_side[1];
      div_req.dividend  = e_side[1] ? (pos + ext_hi + margin) : (pos - ext_lo - margin);
      div_req.divisor   = e_side[0] ? cfg_ff[REG_CELL_HEIGHT] : cfg_ff[REG_CELL_WIDTH];
      div_req.limit     = e_side[0] ? COORD_W'(GRID_ROWS) : COORD_W'(GRID_COLS);
   end

   gcrt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign ram_we    = (state_ff == S_CLEAR) || p_valid_ff;
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_ff : p_addr_ff;
   assign ram_wdata = (state_ff == S_CLEAR) ? ST_UNLOADED : p_status_ff;
   assign ram_raddr = (state_ff == S_IDLE)
                      ? cell_addr(COORD_W'(req_chan.cell_row), COORD_W'(req_chan.cell_col))
                      : cell_addr(r_ff, c_ff);

   gcrt_ram #(
      .WIDTH (2),
      .DEPTH (CELLS)
   ) u_status_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      cfg_in         = cfg_ff;
      clr_in         = clr_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      edge_in        = edge_ff;
      e_in           = e_ff;
      prev_view_in   = prev_view_ff;
      prev_pre_in    = prev_pre_ff;
      pass_in        = pass_ff;
      c_in           = c_ff;
      r_in           = r_ff;
      p_valid_in     = 1'b0;
      p_addr_in      = cell_addr(r_ff, c_ff);
      p_status_in    = pass_ff ? (in_view ? ST_SHOWN : ST_LOADED)
                               : (in_keep ? ST_HIDDEN : ST_UNLOADED);
      cnt_in         = cnt_ff;
      rd_ok_in       = rd_ok_ff;
      res_status_in  = res_status_ff;
      res_changed_in = res_changed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_cnt_in     = rsp_cnt_ff;

      if (csr_we) begin
         cfg_in[csr_index] = csr_wdata;
      end

      // write-back stage: old status comes from the read issued last cycle
      if (p_valid_ff) begin
         for (int i = 0; i < 4; i++) begin
            cnt_in[i] = cnt_ff[i] + CNT_W'(p_status_ff == status_type'(i))
                                  - CNT_W'(ram_rdata == 2'(i));
         end
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               res_status_in  = ST_UNLOADED;
               res_changed_in = 1'b0;
               if (req_chan.kind) begin
                  rd_ok_in = (int'(req_chan.cell_col) < GRID_COLS) &&
                             (int'(req_chan.cell_row) < GRID_ROWS);
                  state_in = S_READ;
               end else begin
                  vx_in    = req_chan.view_x;
                  vy_in    = req_chan.view_y;
                  e_in     = '0;
                  state_in = S_EDGE;
               end
            end
         end
         S_READ: begin
            res_status_in = rd_ok_ff ? status_type'(ram_rdata) : ST_UNLOADED;
            state_in      = S_DONE;
         end
         S_EDGE: begin
            state_in = S_EDGE_WAIT;
         end
         S_EDGE_WAIT: begin
            if (div_rsp.done) begin
               edge_in[e_ff] = div_rsp.quotient;
               if (e_ff == EDGE_IDX_W'(EDGE_NUM - 1)) begin
                  state_in = S_CHECK;
               end else begin
                  e_in     = e_ff + EDGE_IDX_W'(1);
                  state_in = S_EDGE;
               end
            end
         end
         S_CHECK: begin
            if (new_view == prev_view_ff) begin
               res_changed_in = 1'b0;
               state_in       = S_FINISH;
            end else begin
               res_changed_in = 1'b1;
               pass_in        = 1'b0;
               state_in       = S_PASS;
            end
         end
         S_PASS: begin
            if (cur_empty) begin
               if (pass_ff) begin
                  state_in = S_FINISH;
               end else begin
                  pass_in = 1'b1;
               end
            end else begin
               c_in     = cur.x0;
               r_in     = cur.y0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            p_valid_in = !in_common;
            if (c_ff + COORD_W'(1) == cur.x1) begin
               c_in = cur.x0;
               if (r_ff + COORD_W'(1) == cur.y1) begin
                  state_in = S_DRAIN;
               end else begin
                  r_in = r_ff + COORD_W'(1);
               end
            end else begin
               c_in = c_ff + COORD_W'(1);
            end
         end
         S_DRAIN: begin
            // last write of the region lands here, before the next region reads
            if (pass_ff) begin
               state_in = S_FINISH;
            end else begin
               pass_in  = 1'b1;
               state_in = S_PASS;
            end
         end
         S_FINISH: begin
            prev_view_in = new_view;
            prev_pre_in  = new_pre;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_changed_in = res_changed_ff;
               rsp_cnt_in     = cnt_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cfg_ff       <= '{REG_CELL_WIDTH: CFG_W'(32), REG_CELL_HEIGHT: CFG_W'(32),
                           default: '0};
         clr_ff       <= '0;
         prev_view_ff <= '0;
         prev_pre_ff  <= '0;
         pass_ff      <= 1'b0;
         e_ff         <= '0;
         p_valid_ff   <= 1'b0;
         cnt_ff       <= '{ST_UNLOADED: CNT_W'(CELLS), default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         clr_ff       <= clr_in;
         prev_view_ff <= prev_view_in;
         prev_pre_ff  <= prev_pre_in;
         pass_ff      <= pass_in;
         e_ff         <= e_in;
         p_valid_ff   <= p_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      edge_ff        <= edge_in;
      c_ff           <= c_in;
      r_ff           <= r_in;
      p_addr_ff      <= p_addr_in;
      p_status_ff    <= p_status_in;
      rd_ok_ff       <= rd_ok_in;
      res_status_ff  <= res_status_in;
      res_changed_ff <= res_changed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.cell_status    = rsp_status_ff;
   assign rsp_chan.region_changed = rsp_changed_ff;
   assign rsp_chan.unloaded_count = rsp_cnt_ff[ST_UNLOADED];
   assign rsp_chan.loaded_count   = rsp_cnt_ff[ST_LOADED];
   assign rsp_chan.shown_count    = rsp_cnt_ff[ST_SHOWN];
   assign rsp_chan.hidden_count   = rsp_cnt_ff[ST_HIDDEN];

   `GCRT_ASSERT(a_count_sum, clock, reset, CNT_W'(cnt_ff[0] + cnt_ff[1] + cnt_ff[2] + cnt_ff[3]) == CNT_W'(CELLS), "status counts do not cover the grid")
   `GCRT_ASSERT(a_ready_drop, clock, reset, req_xfer |=> !req_chan.ready, "request taken while busy")
   `GCRT_ASSERT_NEVER(a_idle_write, clock, reset, ram_we && state_ff == S_IDLE, "status store written while idle")
   `GCRT_ASSERT(a_changed_status, clock, reset, rsp_chan.valid && rsp_chan.region_changed |-> rsp_chan.cell_status == ST_UNLOADED, "update result carries a cell status")

endmodule

/* dv/grid_cell_residency_tracker_test.sv */
// ----------------------------------------------------------------------------
// grid_cell_residency_tracker_test
// Drives view updates and cell reads through the tracker, keeps an own model
// of the cell status grid and compares every response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_cell_residency_tracker_test;
   import gcrt_pkg::*;

   typedef struct {
      longint x0, y0, x1, y1;
   } cell_box;

   typedef struct packed {
      logic [1:0]       cell_status;
      logic             region_changed;
      logic [CNT_W-1:0] unloaded_count;
      logic [CNT_W-1:0] loaded_count;
      logic [CNT_W-1:0] shown_count;
      logic [CNT_W-1:0] hidden_count;
   } residency_rsp;

   // model of the tracker plus queue of expected responses
   class residency_board;
      logic [CFG_W-1:0] regs [CFG_NUM];
      status_type       grid [CELLS];
      cell_box          last_view, last_pre;
      int               counts [4];
      residency_rsp     pending [$];
      int               errors;

      function new();
         for (int i = 0; i < CELLS; i++) grid[i] = ST_UNLOADED;
         foreach (regs[i]) regs[i] = 0;
         regs[REG_CELL_WIDTH] = 32;
         regs[REG_CELL_HEIGHT] = 32;
         last_view = '{0, 0, 0, 0};
         last_pre = '{0, 0, 0, 0};
         counts = '{CELLS, 0, 0, 0};
         errors = 0;
      endfunction

      function longint fdiv(longint a, longint d);
         longint q;
         q = a / d;
         if (a % d != 0 && a < 0) q -= 1;
         return q;
      endfunction

      function longint cdiv(longint a, longint d);
         longint q;
         q = a / d;
         if (a % d != 0 && a > 0) q += 1;
         return q;
      endfunction

      function longint clip(longint v, longint hi);
         return v < 0 ? 0 : (v > hi ? hi : v);
      endfunction

      function cell_box snap(longint x, longint y, longint w, longint h);
         longint cw, ch;
         cell_box b;
         cw = regs[REG_CELL_WIDTH] == 0 ? 1 : regs[REG_CELL_WIDTH];
         ch = regs[REG_CELL_HEIGHT] == 0 ? 1 : regs[REG_CELL_HEIGHT];
         b.x0 = clip(fdiv(x, cw), GRID_COLS);
         b.y0 = clip(fdiv(y, ch), GRID_ROWS);
         b.x1 = clip(cdiv(x + w, cw), GRID_COLS);
         b.y1 = clip(cdiv(y + h, ch), GRID_ROWS);
         return b;
      endfunction

      function bit holds(cell_box b, longint c, longint r);
         return c >= b.x0 && c < b.x1 && r >= b.y0 && r < b.y1;
      endfunction

      function bit move_view(longint vx, longint vy);
         longint bx, by, ox, oy, w, h;
         cell_box vw, pre, keep, ov, op, both;
         bx = regs[REG_BORDER_X];
         by = regs[REG_BORDER_Y];
         ox = vx - longint'(regs[REG_VIEW_LEFT]);
         oy = vy - longint'(regs[REG_VIEW_DOWN]);
         w = longint'(regs[REG_VIEW_LEFT]) + longint'(regs[REG_VIEW_RIGHT]);
         h = longint'(regs[REG_VIEW_DOWN]) + longint'(regs[REG_VIEW_UP]);
         vw = snap(ox, oy, w, h);
         pre = snap(ox - bx, oy - by, w + 2 * bx, h + 2 * by);
         keep = snap(ox - 3 * bx, oy - 3 * by, w + 6 * bx, h + 6 * by);
         ov = last_view;
         op = last_pre;
         last_view = vw;
         last_pre = pre;
         if (ov == vw) return 0;
         both.x0 = ov.x0 > vw.x0 ? ov.x0 : vw.x0;
         both.y0 = ov.y0 > vw.y0 ? ov.y0 : vw.y0;
         both.x1 = ov.x1 < vw.x1 ? ov.x1 : vw.x1;
         both.y1 = ov.y1 < vw.y1 ? ov.y1 : vw.y1;
         if (!(both.x1 > both.x0 && both.y1 > both.y0)) both = '{0, 0, 0, 0};
         for (longint r = op.y0; r < op.y1; r++)
            for (longint c = op.x0; c < op.x1; c++)
               if (!holds(both, c, r))
                  grid[r * GRID_COLS + c] = holds(keep, c, r) ? ST_HIDDEN : ST_UNLOADED;
         for (longint r = pre.y0; r < pre.y1; r++)
            for (longint c = pre.x0; c < pre.x1; c++)
               if (!holds(both, c, r))
                  grid[r * GRID_COLS + c] = holds(vw, c, r) ? ST_SHOWN : ST_LOADED;
         counts = '{0, 0, 0, 0};
         for (int i = 0; i < CELLS; i++) counts[grid[i]]++;
         return 1;
      endfunction

      function void note_request(logic kind, logic signed [POS_W-1:0] vx,
                                 logic signed [POS_W-1:0] vy,
                                 logic [LOC_W-1:0] col, logic [LOC_W-1:0] row);
         residency_rsp e;
         e.cell_status = ST_UNLOADED;
         e.region_changed = 0;
         if (kind == 0)
            e.region_changed = move_view(longint'(vx), longint'(vy));
         else if (col < GRID_COLS && row < GRID_ROWS)
            e.cell_status = grid[int'(row) * GRID_COLS + int'(col)];
         e.unloaded_count = CNT_W'(counts[ST_UNLOADED]);
         e.loaded_count = CNT_W'(counts[ST_LOADED]);
         e.shown_count = CNT_W'(counts[ST_SHOWN]);
         e.hidden_count = CNT_W'(counts[ST_HIDDEN]);
         pending.push_back(e);
      endfunction

      function void check_response(residency_rsp got);
         residency_rsp e;
         if (pending.size() == 0) begin
            $error("response with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.cell_status !== e.cell_status) begin
            $error("cell_status expected %0d actual %0d", e.cell_status, got.cell_status);
            errors++;
         end
         if (got.region_changed !== e.region_changed) begin
            $error("region_changed expected %0d actual %0d",
                   e.region_changed, got.region_changed);
            errors++;
         end
         if (got.unloaded_count !== e.unloaded_count) begin
            $error("unloaded_count expected %0d actual %0d",
                   e.unloaded_count, got.unloaded_count);
            errors++;
         end
         if (got.loaded_count !== e.loaded_count) begin
            $error("loaded_count expected %0d actual %0d", e.loaded_count, got.loaded_count);
            errors++;
         end
         if (got.shown_count !== e.shown_count) begin
            $error("shown_count expected %0d actual %0d", e.shown_count, got.shown_count);
            errors++;
         end
         if (got.hidden_count !== e.hidden_count) begin
            $error("hidden_count expected %0d actual %0d", e.hidden_count, got.hidden_count);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_we = 0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   int                   send_idle = 0;
   int                   take_idle = 0;
   int                   quiet_cycles = 0;
   residency_board       board;

   gcrt_req_if req_chan ();
   gcrt_rsp_if rsp_chan ();

   grid_cell_residency_tracker dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.kind = 0;
      req_chan.view_x = 0;
      req_chan.view_y = 0;
      req_chan.cell_col = 0;
      req_chan.cell_row = 0;
      rsp_chan.ready = 0;
   end

   // receiver: random stall, check on each transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_response({rsp_chan.cell_status, rsp_chan.region_changed,
                                  rsp_chan.unloaded_count, rsp_chan.loaded_count,
                                  rsp_chan.shown_count, rsp_chan.hidden_count});
         rsp_chan.ready <= ($urandom_range(99) >= take_idle);
      end
   end

   // watchdog on cycles without any transfer; clearing pass and a full update fit
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // valid stays up into the next send; idle cycles and drain() drop it
   task automatic send(logic kind, logic signed [POS_W-1:0] vx, logic signed [POS_W-1:0] vy,
                       logic [LOC_W-1:0] col, logic [LOC_W-1:0] row);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.kind <= kind;
      req_chan.view_x <= vx;
      req_chan.view_y <= vy;
      req_chan.cell_col <= col;
      req_chan.cell_row <= row;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(kind, vx, vy, col, row);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CFG_W-1:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      board.regs[idx] = value;
   endtask

   task automatic random_reads(int n);
      repeat (n) send(1, $urandom, $urandom, $urandom, $urandom);
   endtask

   // random view setup: mostly small cells and extents so moves touch the grid
   task automatic random_setup(bit wide);
      write_reg(REG_CELL_WIDTH, wide ? $urandom : $urandom_range(64));
      write_reg(REG_CELL_HEIGHT, wide ? $urandom : $urandom_range(64));
      write_reg(REG_VIEW_UP, wide ? $urandom : $urandom_range(200));
      write_reg(REG_VIEW_DOWN, wide ? $urandom : $urandom_range(200));
      write_reg(REG_VIEW_LEFT, wide ? $urandom : $urandom_range(200));
      write_reg(REG_VIEW_RIGHT, wide ? $urandom : $urandom_range(200));
      write_reg(REG_BORDER_X, wide ? $urandom : $urandom_range(60));
      write_reg(REG_BORDER_Y, wide ? $urandom : $urandom_range(60));
   endtask

   initial begin
      int ph, x, y;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed
      send(1, 0, 0, 0, 0);
      send(0, 0, 0, 63, 63);
      send(0, 100, 100, 0, 0);
      send(0, 100, 100, 0, 0);
      drain();
      write_reg(REG_VIEW_UP, 100);
      write_reg(REG_VIEW_DOWN, 50);
      write_reg(REG_VIEW_LEFT, 70);
      write_reg(REG_VIEW_RIGHT, 90);
      write_reg(REG_BORDER_X, 40);
      write_reg(REG_BORDER_Y, 30);
      send(0, 500, 600, 0, 0);
      send(1, 0, 0, 16, 19);
      send(0, 700, 620, 0, 0);
      send(1, 0, 0, 16, 19);
      send(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0);
      send(0, 32'sh80000000, 32'sh80000000, 0, 0);
      send(0, -20, -20, 0, 0);
      drain();
      write_reg(REG_CELL_WIDTH, 0);
      write_reg(REG_CELL_HEIGHT, 0);
      write_reg(REG_BORDER_X, 16'hFFFF);
      write_reg(REG_BORDER_Y, 16'hFFFF);
      write_reg(REG_VIEW_UP, 16'hFFFF);
      write_reg(REG_VIEW_RIGHT, 16'hFFFF);
      send(0, 10, 10, 0, 0);
      send(1, 0, 0, 63, 0);
      send(1, 0, 0, 0, 63);
      drain();
      write_reg(REG_CELL_WIDTH, 16'hFFFF);
      write_reg(REG_CELL_HEIGHT, 1);
      send(0, -70000, 20, 0, 0);
      send(1, 0, 0, 0, 20);
      drain();

      // random phases over three idling profiles
      for (ph = 0; ph < 24; ph++) begin
         send_idle = ph < 8 ? 35 : (ph < 16 ? 53 : 0);
         take_idle = ph < 8 ? 53 : (ph < 16 ? 35 : 0);
         drain();
         random_setup(ph % 6 == 5);
         x = $urandom_range(2000) - 300;
         y = $urandom_range(2000) - 300;
         repeat (12) begin
            if ($urandom_range(9) == 0)
               send(0, $urandom, $urandom, $urandom, $urandom);
            else begin
               x += int'($urandom_range(160)) - 80;
               y += int'($urandom_range(160)) - 80;
               send(0, x, y, $urandom, $urandom);
            end
            random_reads(2);
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
